/* src/kfce_pkg.sv */
// Shared types and constants of the keyframe curve evaluator.
// No dependencies; every other file of the block but kfce_ram imports this package.
package kfce_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int KEY_IDX_W  = $clog2(MAX_KEYS);
    localparam int KEY_CNT_W  = $clog2(MAX_KEYS + 1);

    // Step counts of the shared remainder divider.
    localparam int DIV_STEP_W = 6;
    localparam int WRAP_STEPS = 32;
    localparam int POS_STEPS  = 16;

    // Smoothstep constant 3.0 in Q2.16, from which the 2*u term is subtracted.
    localparam logic [17:0] SMOOTH_K = 18'd196608;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_EVAL   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        CFG_LOOP_ENABLE   = 1'b0,
        CFG_LOOP_DURATION = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_CHECK,
        ST_SCAN,
        ST_DIVIDE,
        ST_BLEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] key_time;
        logic signed [31:0] key_value;
        logic signed [31:0] query_time;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] curve_value;
    } rsp_t;

    // One stored keyframe: time and value, both Q16.16.
    typedef struct packed {
        logic signed [31:0] kt;
        logic signed [31:0] kv;
    } key_entry_t;

    localparam int KEY_W = $bits(key_entry_t);

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
        logic [31:0]           divisor;
        logic [31:0]           rem_init;
        logic [31:0]           dividend;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [15:0]        u;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
    } blend_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } blend_rsp_t;

endpackage

/* src/kfce_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used by the keyframe curve evaluator for its key table.
module kfce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/kfce_div.sv */
// Restoring remainder divider, one quotient bit per cycle.
// Depends on kfce_pkg; shared by loop wrapping and segment position.
module kfce_div
    import kfce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0]           d_reg;
    logic [31:0]           r_reg;
    logic [31:0]           r_next;
    logic [31:0]           sh_reg;
    logic [31:0]           q_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [32:0]           trial;
    logic                  fits;

    // The partial remainder stays below the divisor, so one compare and
    // subtract per step suffices.
    assign trial  = {r_reg, sh_reg[31]};
    assign fits   = trial >= {1'b0, d_reg};
    assign r_next = fits ? 32'(trial - {1'b0, d_reg}) : trial[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            d_reg  <= req.divisor;
            r_reg  <= req.rem_init;
            sh_reg <= req.dividend;
            q_reg  <= '0;
        end
        else if (busy_reg)
        begin
            r_reg  <= r_next;
            sh_reg <= {sh_reg[30:0], 1'b0};
            q_reg  <= {q_reg[30:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

/* src/kfce_blend.sv */
// Smoothstep of the segment position and linear blend of the two key values.
// Depends on kfce_pkg; four register stages, with a multiplier in each of the first three.
module kfce_blend
    import kfce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  blend_req_t req,
    output blend_rsp_t rsp
);

    logic [2:0]         vld_reg;
    logic               done_reg;
    logic [31:0]        uu_reg;
    logic [17:0]        w_reg;
    logic signed [32:0] dv_reg;
    logic signed [31:0] v0_reg;
    logic [16:0]        s_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] res_reg;
    logic [49:0]        cube;

    assign cube = uu_reg * w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[1:0], req.start};
            done_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            uu_reg <= req.u * req.u;
            w_reg  <= SMOOTH_K - {1'b0, req.u, 1'b0};
            dv_reg <= $signed({req.v1[31], req.v1}) - $signed({req.v0[31], req.v0});
            v0_reg <= req.v0;
        end
        if (vld_reg[0])
        begin
            // s = u*u*(3 - 2u) in Q1.16; never above 1.0.
            s_reg <= cube[48:32];
        end
        if (vld_reg[1])
        begin
            prod_reg <= dv_reg * $signed({1'b0, s_reg});
        end
        if (vld_reg[2])
        begin
            // An arithmetic shift floors toward minus infinity; the sum fits in 32 bits.
            res_reg <= v0_reg + prod_reg[47:16];
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

/* src/keyframe_curve_evaluator_unit.sv */
// Keyframe curve evaluator: a 64-entry key table in RAM with an evaluation sequencer.
// Depends on kfce_pkg, kfce_ram, kfce_div and kfce_blend.
//
// Usage: items arrive on the cmd channel (cmd_valid / cmd_stall) and each one
// produces exactly one item on the rsp channel (rsp_valid / rsp_stall).
// A clear or append item, or an empty-table evaluate item, has its result registered;
// it shows on rsp the cycle after acceptance. Other evaluate items walk the table in
// RAM: three reads fetch the last, first and second keys while the clamp is checked,
// then the scan examines one segment per cycle, then 16 steps of the shared divider
// give the position, followed by the smoothstep multiplier chain and the loading of
// the result. With looping active, more than one key and the query time outside the
// loop, the wrap runs the shared divider up front. One item is in work at a time.
// The table RAM has one read port, which sets the one-segment-per-cycle scan.
// The result register parts the two channels: a finished item waits there
// while the receiver stalls, and no new item is accepted until it can leave.
// Reset empties the table (key count zero) and clears loop_enable and
// loop_duration; RAM contents are not cleared and are never used unwritten.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module keyframe_curve_evaluator_unit
    import kfce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_t        cmd,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_index,
    input  logic [30:0] cfg_data
);

    state_t                state_reg;
    state_t                state_next;
    logic [KEY_CNT_W-1:0]  count_reg;
    logic                  loop_en_reg;
    logic [30:0]           loop_dur_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic signed [31:0]    t_reg;
    logic                  wrap_neg_reg;
    logic signed [31:0]    last_t_reg;
    logic signed [31:0]    last_v_reg;
    logic signed [31:0]    prev_t_reg;
    logic signed [31:0]    prev_v_reg;
    logic signed [31:0]    seg_v0_reg;
    logic signed [31:0]    seg_v1_reg;
    logic signed [31:0]    res_reg;
    logic [KEY_IDX_W-1:0]  idx_reg;

    logic                  ram_we;
    logic [KEY_IDX_W-1:0]  ram_waddr;
    logic [KEY_W-1:0]      ram_wdata;
    logic [KEY_IDX_W-1:0]  ram_raddr;
    logic [KEY_W-1:0]      ram_rdata;
    key_entry_t            ram_rd;

    div_req_t              div_req;
    div_rsp_t              div_rsp;
    blend_req_t            blend_req;
    blend_rsp_t            blend_rsp;

    logic                  cmd_fire;
    logic                  rsp_free;
    logic                  rsp_load;
    rsp_t                  rsp_load_item;
    logic                  table_full;
    logic [KEY_CNT_W-1:0]  last_idx;
    logic                  wrap_on;
    logic                  q_above;
    logic                  q_neg;
    logic                  eval_go;
    logic                  wrap_start;
    logic                  at_first;
    logic                  at_last;
    logic                  seg_hit;
    logic [32:0]           diff_w;
    logic [32:0]           span_w;
    logic                  seg_exact;
    logic                  scan_last;
    logic signed [31:0]    wrapped;

    // ------------------------------------------------------------------
    // Units
    // ------------------------------------------------------------------
    kfce_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kfce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    kfce_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (blend_req),
        .rsp   (blend_rsp)
    );

    // ------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------
    assign ram_rd     = key_entry_t'(ram_rdata);
    assign cmd_fire   = cmd_valid && !cmd_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign table_full = count_reg == KEY_CNT_W'(MAX_KEYS);
    assign last_idx   = count_reg - 1'b1;

    assign wrap_on    = loop_en_reg && (loop_dur_reg != '0);
    assign q_above    = $signed(cmd.query_time) > $signed({1'b0, loop_dur_reg});
    assign q_neg      = cmd.query_time[31];
    assign eval_go    = cmd_fire && (cmd.func == FUNC_EVAL) && (count_reg != '0);
    // A single key is returned as it is, so only longer tables wrap.
    assign wrap_start = eval_go && (count_reg > KEY_CNT_W'(1)) && wrap_on
                        && (q_above || q_neg);

    assign wrapped = wrap_neg_reg
                     ? ((div_rsp.remainder == '0) ? 32'sd0
                        : $signed({1'b0, loop_dur_reg} - div_rsp.remainder))
                     : $signed(div_rsp.remainder + 32'd1);

    assign at_first = $signed(t_reg) <= $signed(ram_rd.kt);
    assign at_last  = $signed(t_reg) >= $signed(last_t_reg);

    // Segment held in prev (left key) and the RAM output (right key).
    assign seg_hit   = ($signed(t_reg) >= $signed(prev_t_reg))
                       && ($signed(t_reg) <= $signed(ram_rd.kt));
    assign diff_w    = $signed({t_reg[31], t_reg}) - $signed({prev_t_reg[31], prev_t_reg});
    assign span_w    = $signed({ram_rd.kt[31], ram_rd.kt})
                       - $signed({prev_t_reg[31], prev_t_reg});
    // Time on the right key, including a zero-width segment, gives the right value.
    assign seg_exact = diff_w[31:0] == span_w[31:0];
    assign scan_last = KEY_CNT_W'(idx_reg) == last_idx;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (wrap_start)
                begin
                    state_next = ST_WRAP;
                end
                else if (eval_go)
                begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_WRAP:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST:  state_next = ST_RD_FIRST;
            ST_RD_FIRST: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (at_first || at_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (seg_hit)
                begin
                    state_next = seg_exact ? ST_DONE : ST_DIVIDE;
                end
                else if (scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (blend_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_stall     = (state_reg != ST_IDLE) || !rsp_free;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[KEY_IDX_W-1:0];
        ram_wdata     = {cmd.key_time, cmd.key_value};
        ram_raddr     = '0;
        div_req       = '0;
        blend_req     = '0;
        rsp_load      = 1'b0;
        rsp_load_item = '{status: STATUS_OK, curve_value: res_reg};

        case (state_reg)
            ST_IDLE:
            begin
                div_req.steps    = DIV_STEP_W'(WRAP_STEPS);
                div_req.divisor  = {1'b0, loop_dur_reg};
                div_req.rem_init = '0;
                // Above the loop: ((t-1) mod d) + 1. Negative: d - (-t mod d), or 0 where -t mod d is 0.
                div_req.dividend = q_neg ? 32'(32'd0 - cmd.query_time)
                                         : 32'(cmd.query_time - 32'sd1);
                div_req.start    = wrap_start;
                if (cmd_fire)
                begin
                    ram_we                    = (cmd.func == FUNC_APPEND) && !table_full;
                    rsp_load                  = !eval_go;
                    rsp_load_item.curve_value = '0;
                    if ((cmd.func == FUNC_APPEND) && table_full)
                    begin
                        rsp_load_item.status = STATUS_FULL;
                    end
                    else if (cmd.func == FUNC_EVAL)
                    begin
                        rsp_load_item.status = STATUS_EMPTY;
                    end
                end
            end
            ST_RD_LAST:  ram_raddr = last_idx[KEY_IDX_W-1:0];
            ST_RD_FIRST: ram_raddr = '0;
            ST_CHECK:    ram_raddr = KEY_IDX_W'(1);
            ST_SCAN:
            begin
                ram_raddr        = KEY_IDX_W'(idx_reg + 1'b1);
                div_req.steps    = DIV_STEP_W'(POS_STEPS);
                div_req.divisor  = span_w[31:0];
                div_req.rem_init = diff_w[31:0];
                div_req.dividend = '0;
                div_req.start    = seg_hit && !seg_exact;
            end
            ST_DIVIDE:
            begin
                blend_req.start = div_rsp.done;
                blend_req.u     = div_rsp.quotient[15:0];
                blend_req.v0    = seg_v0_reg;
                blend_req.v1    = seg_v1_reg;
            end
            ST_DONE:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            loop_en_reg   <= 1'b0;
            loop_dur_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cmd_fire && (cmd.func == FUNC_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (ram_we)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOOP_ENABLE:   loop_en_reg  <= cfg_data[0];
                    CFG_LOOP_DURATION: loop_dur_reg <= cfg_data;
                    default:           loop_en_reg  <= loop_en_reg;
                endcase
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_load_item;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    t_reg        <= cmd.query_time;
                    wrap_neg_reg <= q_neg;
                end
            end
            ST_WRAP:
            begin
                if (div_rsp.done)
                begin
                    t_reg <= wrapped;
                end
            end
            ST_RD_FIRST:
            begin
                last_t_reg <= ram_rd.kt;
                last_v_reg <= ram_rd.kv;
            end
            ST_CHECK:
            begin
                prev_t_reg <= ram_rd.kt;
                prev_v_reg <= ram_rd.kv;
                idx_reg    <= KEY_IDX_W'(1);
                res_reg    <= at_first ? ram_rd.kv : last_v_reg;
            end
            ST_SCAN:
            begin
                if (seg_hit)
                begin
                    seg_v0_reg <= prev_v_reg;
                    seg_v1_reg <= ram_rd.kv;
                    res_reg    <= ram_rd.kv;
                end
                else if (scan_last)
                begin
                    res_reg <= last_v_reg;
                end
                else
                begin
                    prev_t_reg <= ram_rd.kt;
                    prev_v_reg <= ram_rd.kv;
                    idx_reg    <= KEY_IDX_W'(idx_reg + 1'b1);
                end
            end
            ST_BLEND:
            begin
                if (blend_rsp.done)
                begin
                    res_reg <= blend_rsp.value;
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= KEY_CNT_W'(MAX_KEYS))
        else $error("key count beyond table depth");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_WRAP || state_reg == ST_DIVIDE))
        else $error("divider finished with no step waiting for it");

    a_blend_owner: assert property (@(posedge clk) disable iff (!rst_n)
        blend_rsp.done |-> (state_reg == ST_BLEND))
        else $error("blend finished outside the blend step");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.func == FUNC_APPEND) && !table_full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted append did not grow the table");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !rsp_load)
        else $error("result overwritten while the receiver stalls");

endmodule

/* test/tb_keyframe_curve_evaluator_unit.sv */
// Self-checking testbench for keyframe_curve_evaluator_unit: directed curves, then
// random keyframe tables and queries under random idling, checked against a predictor.
// Depends on kfce_pkg and the RTL of the block.
module tb_keyframe_curve_evaluator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import kfce_pkg::*;

    typedef longint unsigned u64_t;

    localparam int Q_TOP         = 32'h7FFF_FFFF;
    localparam int Q_BOTTOM      = 32'h8000_0000;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 200;

    // Predicts the curve for every accepted item and checks results in order.
    class curve_scoreboard;
        longint knot_time [MAX_KEYS];
        longint knot_value[MAX_KEYS];
        int     n_keys;
        bit     loop_on;
        longint loop_len;
        rsp_t   awaited_results[$];
        int     errors;

        function void set_loop(bit en, logic [30:0] dur);
            loop_on  = en;
            loop_len = dur;
        endfunction

        // Times past the period land in (0, d], negative times in [0, d).
        function longint fold_into_loop(longint t);
            longint m;
            if (t > loop_len)
                return (t - 1) % loop_len + 1;
            if (t < 0)
            begin
                m = (-t) % loop_len;
                return (m == 0) ? 0 : loop_len - m;
            end
            return t;
        endfunction

        function longint smooth_mix(longint t, longint t0, longint t1, longint v0, longint v1);
            longint span;
            longint u;
            longint s;
            longint prod;
            span = t1 - t0;
            if (span == 0)
                return v1;
            u = ((t - t0) <<< 16) / span;
            if (u > 65536)
                u = 65536;
            s = (u * u * (196608 - 2 * u)) >>> 32;
            prod = (v1 - v0) * s;
            // The arithmetic shift rounds toward minus infinity.
            return v0 + (prod >>> 16);
        endfunction

        function longint curve_at(longint t);
            int i;
            if (n_keys == 1)
                return knot_value[0];
            if (loop_on && loop_len > 0)
                t = fold_into_loop(t);
            if (t <= knot_time[0])
                return knot_value[0];
            if (t >= knot_time[n_keys - 1])
                return knot_value[n_keys - 1];
            for (i = 0; i + 1 < n_keys; i++)
            begin
                if (t >= knot_time[i] && t <= knot_time[i + 1])
                    return smooth_mix(t, knot_time[i], knot_time[i + 1],
                                      knot_value[i], knot_value[i + 1]);
            end
            return knot_value[n_keys - 1];
        endfunction

        function void take_command(cmd_t c);
            rsp_t r;
            r = '0;
            r.status = STATUS_OK;
            case (c.func)
                FUNC_CLEAR:
                    n_keys = 0;
                FUNC_APPEND:
                    if (n_keys >= MAX_KEYS)
                        r.status = STATUS_FULL;
                    else
                    begin
                        knot_time[n_keys]  = c.key_time;
                        knot_value[n_keys] = c.key_value;
                        n_keys++;
                    end
                FUNC_EVAL:
                    if (n_keys == 0)
                        r.status = STATUS_EMPTY;
                    else
                        r.curve_value = 32'(curve_at(c.query_time));
                default:
                    ;
            endcase
            awaited_results.insert(awaited_results.size(), r);
        endfunction

        function void match_response(rsp_t got);
            rsp_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result item with none awaited: status %0d curve_value %0d",
                       got.status, got.curve_value);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.curve_value !== want.curve_value)
            begin
                $error("curve_value: expected %0d (%h), got %0d (%h)",
                       want.curve_value, want.curve_value, got.curve_value, got.curve_value);
                errors++;
            end
        endfunction

        function int awaited();
            return awaited_results.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_we    = 1'b0;
    cfg_idx_t    cfg_index = CFG_LOOP_ENABLE;
    logic [30:0] cfg_data  = '0;

    curve_scoreboard sb = new;

    bit          idle_allowed     = 1'b1;
    bit          idle_on          = 1'b1;
    int          items_sent       = 0;
    int          long_holds_asked = 0;
    int          holds_granted    = 0;
    int          stall_left       = 0;
    int unsigned cycle_count      = 0;

    keyframe_curve_evaluator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check each accepted item, then choose the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.match_response(rsp);
            if (holds_granted != long_holds_asked)
            begin
                holds_granted++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                stall_left = $urandom_range(0, 8);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    function automatic longint pick_between(longint a, longint b);
        u64_t r;
        if (b <= a)
            return a;
        r = {$urandom, $urandom};
        return a + longint'(r % u64_t'(b - a + 1));
    endfunction

    function automatic int to_q32(longint x);
        if (x > Q_TOP)
            return Q_TOP;
        if (x < Q_BOTTOM)
            return Q_BOTTOM;
        return int'(x);
    endfunction

    function automatic cmd_t make_cmd(func_t f, int kt, int kv, int qt);
        cmd_t c;
        c.func       = f;
        c.key_time   = kt;
        c.key_value  = kv;
        c.query_time = qt;
        return c;
    endfunction

    // Query times in the key range, near keys, around the loop or wider, or random.
    function automatic int pick_query(longint lo, longint hi);
        longint w;
        longint d;
        int     pick;
        w = hi - lo + 1;
        d = sb.loop_len;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return to_q32(pick_between(lo, hi));
        if (pick < 60 && sb.n_keys > 0)
            return to_q32(sb.knot_time[$urandom_range(0, sb.n_keys - 1)]
                          + int'($urandom_range(0, 2)) - 1);
        if (pick < 80 && sb.loop_on && d > 0)
            return to_q32(pick_between(-3 * d - 1, 3 * d + 1));
        if (pick < 80)
            return to_q32(pick_between(lo - w, hi + w));
        return int'($urandom);
    endfunction

    task automatic send_item(input cmd_t c);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.take_command(c);
        items_sent++;
    endtask

    task automatic clear_table();
        send_item(make_cmd(FUNC_CLEAR, $urandom, $urandom, $urandom));
    endtask

    task automatic append_key(input int t, input int v);
        send_item(make_cmd(FUNC_APPEND, t, v, $urandom));
    endtask

    task automatic evaluate_at(input int q);
        send_item(make_cmd(FUNC_EVAL, $urandom, $urandom, q));
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (sb.awaited() != 0)
            @(posedge clk);
    endtask

    task automatic write_loop_regs(input bit en, input logic [30:0] dur);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOOP_ENABLE;
        cfg_data  <= {30'd0, en};
        @(posedge clk);
        cfg_index <= CFG_LOOP_DURATION;
        cfg_data  <= dur;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_loop(en, dur);
    endtask

    // One table load followed by a few evaluations. Scrambled tables take keys in
    // any order; a fill runs past the table size so that appends get dropped.
    task automatic play_curve(input bit scrambled, input bit fill);
        int     n;
        int     pick;
        int     i;
        longint t;
        longint stride;
        longint lo;
        longint hi;
        longint kt;
        int     kv;
        pick = $urandom_range(0, 99);
        if (fill || pick < 5)
            n = $urandom_range(MAX_KEYS + 1, MAX_KEYS + 4);
        else if (pick < 15)
            n = $urandom_range(9, MAX_KEYS);
        else
            n = $urandom_range(1, 8);
        if (sb.loop_on && sb.loop_len != 0 && $urandom_range(0, 1) == 1)
        begin
            t = pick_between(0, sb.loop_len / 4);
            stride = sb.loop_len / n + 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            t = pick_between(Q_BOTTOM, 0);
            stride = (longint'(1) << 32) / n;
        end
        else
        begin
            t = pick_between(-(1 << 20), 1 << 20);
            stride = longint'(1) << $urandom_range(4, 18);
        end
        lo = Q_TOP;
        hi = Q_BOTTOM;
        clear_table();
        for (i = 0; i < n; i++)
        begin
            if (scrambled)
                kt = pick_between(t - stride * n, t + stride * n);
            else
            begin
                kt = t;
                if ($urandom_range(0, 7) != 0)
                    t = t + pick_between(1, stride);
            end
            kt = to_q32(kt);
            if (kt < lo)
                lo = kt;
            if (kt > hi)
                hi = kt;
            if ($urandom_range(0, 3) == 0)
                kv = int'($urandom);
            else
                kv = to_q32(pick_between(-(1 << 24), 1 << 24));
            append_key(int'(kt), kv);
        end
        repeat ($urandom_range(2, 10))
            evaluate_at(pick_query(lo, hi));
    endtask

    task automatic play_noise();
        repeat ($urandom_range(1, 6))
            send_item(make_cmd(func_t'($urandom_range(0, 2)), $urandom, $urandom, $urandom));
    endtask

    task automatic random_phase(input int count);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < count)
        begin
            idle_on = idle_allowed && ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 72)
                play_curve(1'b0, 1'b0);
            else if (pick < 87)
                play_curve(1'b1, 1'b0);
            else
                play_noise();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain lookups: empty table, single key, clamps and segments at the extremes.
        write_loop_regs(1'b0, 31'd0);
        evaluate_at(0);
        append_key(Q_BOTTOM, Q_TOP);
        evaluate_at(Q_TOP);
        clear_table();
        append_key(Q_BOTTOM, Q_BOTTOM);
        append_key(0, Q_TOP);
        append_key(65536, 0);
        append_key(65536, 1000);
        append_key(Q_TOP, Q_BOTTOM);
        evaluate_at(Q_BOTTOM);
        evaluate_at(Q_TOP);
        evaluate_at(-(1 << 30));
        evaluate_at(32768);
        evaluate_at(65536);
        evaluate_at(1);
        evaluate_at(1 << 30);
        // Keys out of order are kept as given.
        clear_table();
        append_key(100000, 5);
        append_key(-100000, 7);
        append_key(200000, 9);
        evaluate_at(150000);
        evaluate_at(0);

        // Looping over a four second period: above, below, at and far outside it.
        write_loop_regs(1'b1, 31'(4 << 16));
        clear_table();
        append_key(0, 0);
        append_key(65536, 1 << 20);
        append_key(4 << 16, -(1 << 20));
        evaluate_at(5 << 16);
        evaluate_at(-65536);
        evaluate_at(-(4 << 16));
        evaluate_at(4 << 16);
        evaluate_at(Q_TOP);
        evaluate_at(Q_BOTTOM);

        write_loop_regs(1'b0, 31'd0);
        play_curve(1'b0, 1'b1);
        random_phase(200);
        write_loop_regs(1'b1, 31'd1);
        random_phase(200);
        write_loop_regs(1'b1, 31'h7FFF_FFFF);
        random_phase(180);
        write_loop_regs(1'b0, 31'h7FFF_FFFF);
        random_phase(150);
        write_loop_regs(1'b1, 31'd0);
        random_phase(150);

        // The receiver holds off for a long while as items keep coming, and later
        // the sender waits for every result before going on.
        write_loop_regs(1'b1, 31'($urandom_range(1, 1 << 20)));
        random_phase(120);
        long_holds_asked++;
        random_phase(120);
        wait_idle();
        random_phase(100);

        write_loop_regs(1'b1, 31'($urandom_range(1 << 20, 32'h7FFF_FFFF)));
        random_phase(230);

        // Last stretch at full rate on both sides.
        write_loop_regs(1'b1, 31'($urandom_range(1, 1 << 22)));
        idle_allowed = 1'b0;
        idle_on      = 1'b0;
        random_phase(200);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* keyframe_curve_evaluator_unit.f */
src/kfce_pkg.sv
src/kfce_ram.sv
src/kfce_div.sv
src/kfce_blend.sv
src/keyframe_curve_evaluator_unit.sv
test/tb_keyframe_curve_evaluator_unit.sv
